@@ design/tpf_pkg.sv @@
// shared types and constants for the tachometer pulse filter
`timescale 1ns / 1ps

package tpf_pkg;

  localparam logic [25:0] US_PER_MIN      = 26'd60000000;
  localparam logic [8:0]  STEADY_ALPHA_Q8 = 9'd51;
  localparam logic [8:0]  ALPHA_ONE       = 9'd256;

  localparam logic [7:0]  PPR_RST      = 8'd1;
  localparam logic [31:0] MIN_PULSE_RST = 32'd2000;
  localparam logic [31:0] TIMEOUT_RST  = 32'd500000;
  localparam logic [31:0] LOW_PER_RST  = 32'd30000;
  localparam logic [6:0]  LOW_PCT_RST  = 7'd60;
  localparam logic [6:0]  NORM_PCT_RST = 7'd80;
  localparam logic [15:0] MOVE_THR_RST = 16'd200;
  localparam logic [8:0]  MOVE_ALPHA_RST = 9'd128;

  localparam logic [2:0] CFG_PPR        = 3'd0;
  localparam logic [2:0] CFG_MIN_PULSE  = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd2;
  localparam logic [2:0] CFG_LOW_PERIOD = 3'd3;
  localparam logic [2:0] CFG_LOW_PCT    = 3'd4;
  localparam logic [2:0] CFG_NORM_PCT   = 3'd5;
  localparam logic [2:0] CFG_MOVE_THR   = 3'd6;
  localparam logic [2:0] CFG_MOVE_ALPHA = 3'd7;

  typedef enum logic [2:0] {
    ST_ACCEPT  = 3'd0,
    ST_REF_SET = 3'd1,
    ST_NOISE   = 3'd2,
    ST_EARLY   = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_UPDATE  = 3'd5
  } edge_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_UPREP,
    S_USAT,
    S_UDIV,
    S_SM1,
    S_SM2,
    S_DONE
  } tpf_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic u_prep;
    logic u_sat;
    logic div_step;
    logic sm1;
    logic sm2;
    logic commit;
  } tpf_cmd_t;

  typedef struct packed {
    logic is_upd;
    logic skip;
    logic sat;
  } tpf_sts_t;

endpackage

@@ design/tpf_ctrl.sv @@
// sequencing state machine for the tachometer pulse filter
`timescale 1ns / 1ps

module tpf_ctrl
  import tpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tpf_sts_t sts,
  output tpf_cmd_t cmd
);

  tpf_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.is_upd && !sts.skip) state_nxt = S_UPREP;
        else state_nxt = S_DONE;
      end
      S_UPREP: begin
        cmd.u_prep = 1'b1;
        state_nxt  = S_USAT;
      end
      S_USAT: begin
        cmd.u_sat = 1'b1;
        cnt_nxt   = 4'd0;
        state_nxt = sts.sat ? S_SM1 : S_UDIV;
      end
      S_UDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_SM1;
      end
      S_SM1: begin
        cmd.sm1   = 1'b1;
        state_nxt = S_SM2;
      end
      S_SM2: begin
        cmd.sm2   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.commit | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

endmodule

@@ design/tpf_dp.sv @@
// datapath: config, filter state, period checks, rpm divider and smoothing
`timescale 1ns / 1ps

module tpf_dp
  import tpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_req_type,
  input  logic [31:0]  in_now_us,
  input  tpf_cmd_t     cmd,
  output tpf_sts_t     sts,
  output logic [15:0]  out_rpm_value,
  output edge_status_t out_edge_status
);

  // configuration
  logic [7:0]  ppr_r;
  logic [31:0] min_pulse_r, timeout_r, low_per_r;
  logic [6:0]  low_pct_r, norm_pct_r;
  logic [15:0] move_thr_r;
  logic [8:0]  move_alpha_r;

  // filter state
  logic        ref_valid_r;
  logic [31:0] last_edge_r, last_good_r, sum_r;
  logic [15:0] count_r, cur_rpm_r;

  // per-item work registers
  logic        req_r;
  logic [31:0] now_r, delta_r;
  logic [38:0] lim_r;
  logic [39:0] per_r;
  logic [41:0] num_r;
  logic [39:0] den_r;
  logic        stop_r, zero_r;
  logic [43:0] nd_r, rem_r;
  logic [40:0] dd_r;
  logic [55:0] dsh_r;
  logic [15:0] q_r;
  logic        first_r;
  logic [8:0]  a_r;
  logic [24:0] p1_r, p2_r;
  logic [15:0] out_rpm_r;
  edge_status_t out_status_r;

  logic [6:0]   pct_sel;
  logic [7:0]   ppr_eff;
  logic         stop_c, zero_c, sat_c, ge_c, early_c;
  logic [15:0]  diff_c;
  logic [8:0]   alpha_mv_c;
  logic [24:0]  smooth_c;
  logic [15:0]  rpm_upd_c;
  logic [32:0]  sum_add_c;
  edge_status_t ed_status_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r        <= PPR_RST;
      min_pulse_r  <= MIN_PULSE_RST;
      timeout_r    <= TIMEOUT_RST;
      low_per_r    <= LOW_PER_RST;
      low_pct_r    <= LOW_PCT_RST;
      norm_pct_r   <= NORM_PCT_RST;
      move_thr_r   <= MOVE_THR_RST;
      move_alpha_r <= MOVE_ALPHA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PPR:        ppr_r        <= cfg_wdata[7:0];
        CFG_MIN_PULSE:  min_pulse_r  <= cfg_wdata;
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        CFG_LOW_PERIOD: low_per_r    <= cfg_wdata;
        CFG_LOW_PCT:    low_pct_r    <= cfg_wdata[6:0];
        CFG_NORM_PCT:   norm_pct_r   <= cfg_wdata[6:0];
        CFG_MOVE_THR:   move_thr_r   <= cfg_wdata[15:0];
        CFG_MOVE_ALPHA: move_alpha_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign pct_sel    = (last_good_r > low_per_r) ? low_pct_r : norm_pct_r;
  assign ppr_eff    = (ppr_r == 8'd0) ? 8'd1 : ppr_r;
  assign stop_c     = !ref_valid_r || (delta_r > timeout_r);
  assign zero_c     = (count_r == 16'd0) || (sum_r == 32'd0);
  assign sat_c      = {13'd0, nd_r} >= {dd_r, 16'd0};
  assign ge_c       = {12'd0, rem_r} >= dsh_r;
  // period < floor(lgp*pct/100) rewritten as 100*period + 100 <= lgp*pct
  assign early_c    = (last_good_r != 32'd0) && (per_r <= {1'b0, lim_r});
  assign diff_c     = (q_r > cur_rpm_r) ? (q_r - cur_rpm_r) : (cur_rpm_r - q_r);
  assign alpha_mv_c = (move_alpha_r > ALPHA_ONE) ? ALPHA_ONE : move_alpha_r;
  assign smooth_c   = p1_r + p2_r + 25'd128;
  assign sum_add_c  = {1'b0, sum_r} + {1'b0, delta_r};

  always_comb begin
    if (stop_r) rpm_upd_c = 16'd0;
    else if (zero_r) rpm_upd_c = cur_rpm_r;
    else if (first_r) rpm_upd_c = q_r;
    else rpm_upd_c = smooth_c[23:8];
  end

  always_comb begin
    if (!ref_valid_r) ed_status_c = ST_REF_SET;
    else if (delta_r < min_pulse_r) ed_status_c = ST_NOISE;
    else if (delta_r > timeout_r) ed_status_c = ST_TIMEOUT;
    else if (early_c) ed_status_c = ST_EARLY;
    else ed_status_c = ST_ACCEPT;
  end

  assign sts.is_upd = req_r;
  assign sts.skip   = stop_c | zero_c;
  assign sts.sat    = sat_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      now_r   <= in_now_us;
      delta_r <= in_now_us - last_edge_r;
    end
    if (cmd.prep) begin
      lim_r  <= 39'(last_good_r) * 39'(pct_sel);
      per_r  <= 40'(delta_r) * 40'd100 + 40'd100;
      num_r  <= 42'(count_r) * 42'(US_PER_MIN);
      den_r  <= 40'(sum_r) * 40'(ppr_eff);
      stop_r <= stop_c;
      zero_r <= zero_c;
    end
    if (cmd.u_prep) begin
      nd_r <= {1'b0, num_r, 1'b0} + 44'(den_r);
      dd_r <= {den_r, 1'b0};
    end
    if (cmd.u_sat) begin
      q_r   <= sat_c ? 16'hFFFF : 16'd0;
      rem_r <= nd_r;
      dsh_r <= {dd_r, 15'd0};
    end
    if (cmd.div_step) begin
      if (ge_c) rem_r <= rem_r - dsh_r[43:0];
      q_r   <= {q_r[14:0], ge_c};
      dsh_r <= {1'b0, dsh_r[55:1]};
    end
    if (cmd.sm1) begin
      first_r <= (cur_rpm_r == 16'd0);
      a_r     <= ({16'd0, diff_c} > {16'd0, move_thr_r}) ? alpha_mv_c : STEADY_ALPHA_Q8;
    end
    if (cmd.sm2) begin
      p1_r <= 25'(a_r) * 25'(q_r);
      p2_r <= 25'(ALPHA_ONE - a_r) * 25'(cur_rpm_r);
    end
    if (cmd.commit) begin
      out_rpm_r    <= req_r ? rpm_upd_c : cur_rpm_r;
      out_status_r <= req_r ? ST_UPDATE : ed_status_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= 1'b0;
      last_edge_r <= 32'd0;
      last_good_r <= 32'd0;
      sum_r       <= 32'd0;
      count_r     <= 16'd0;
      cur_rpm_r   <= 16'd0;
    end else if (cmd.commit) begin
      if (req_r) begin
        sum_r     <= 32'd0;
        count_r   <= 16'd0;
        cur_rpm_r <= rpm_upd_c;
      end else begin
        case (ed_status_c)
          ST_REF_SET: begin
            ref_valid_r <= 1'b1;
            last_edge_r <= now_r;
          end
          ST_TIMEOUT: begin
            last_edge_r <= now_r;
            last_good_r <= 32'd0;
          end
          ST_ACCEPT: begin
            last_edge_r <= now_r;
            last_good_r <= delta_r;
            sum_r       <= sum_add_c[32] ? 32'hFFFF_FFFF : sum_add_c[31:0];
            if (count_r != 16'hFFFF) count_r <= count_r + 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_rpm_value   = out_rpm_r;
  assign out_edge_status = out_status_r;

endmodule

@@ design/tachometer_pulse_filter_rpm.sv @@
// top level of the period-measuring ignition tachometer
`timescale 1ns / 1ps

// Edge and update beats enter on the in_ channel (valid/ready). in_req_type
// low marks a falling ignition edge, high an update poll; in_now_us is the
// free-running microsecond time of the beat. Every input beat yields exactly
// one out_ beat carrying the smoothed rpm and a status code.
// An edge beat goes straight to its result, as does an update beat when the
// engine counts as stopped or nothing was gathered; an update whose rpm
// saturates skips the divider, and any other update runs the 16-step restoring
// divider that forms the rounded rpm quotient. One beat is in work at a time;
// in_ready is high only between beats. The result sits in an output register;
// the next beat can be accepted and worked on while that result waits, and it
// only stalls at its final step. cfg_ writes take effect at once; the user
// must make them while the block is idle, as the block does not enforce it.
// Synchronous active-low reset restores register defaults, clears the
// reference, accumulators and rpm, and empties the output register.
module tachometer_pulse_filter_rpm
  import tpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_req_type,
  input  logic [31:0]  in_now_us,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [15:0]  out_rpm_value,
  output logic [2:0]   out_edge_status
);

  tpf_cmd_t     cmd;
  tpf_sts_t     sts;
  edge_status_t status;

  tpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_now_us       (in_now_us),
    .cmd             (cmd),
    .sts             (sts),
    .out_rpm_value   (out_rpm_value),
    .out_edge_status (status)
  );

  assign out_edge_status = status;

endmodule
